// File: hdl/tbma_pkg.sv
// Package for the typed byte memory access block.
// Holds sizes, op and result codes, and the command and status structs
// shared by the controller, the datapath and the top level. No dependencies.
package tbma_pkg;

  localparam int MEM_BYTES  = 1024;
  localparam int MAX_STRING = 63;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int CALC_W     = (ADDR_W > 13) ? ADDR_W + 1 : 14;
  localparam int ACTIVE_W   = 11;
  localparam int POS_W      = 12;
  localparam int OFF_W      = 12;
  localparam int CNT_W      = 6;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
  localparam logic [OFF_W-1:0]    OFF_SAT      = 12'd4095;

  typedef enum logic [2:0] {
    OP_SET_INT   = 3'd0,
    OP_SET_SHORT = 3'd1,
    OP_SET_CHAR  = 3'd2,
    OP_GET_INT   = 3'd3,
    OP_GET_SHORT = 3'd4,
    OP_GET_CHAR  = 3'd5,
    OP_STR_PUT   = 3'd6,
    OP_STR_GET   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_VIOL  = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  clr_wr;
    logic  load;
    logic  wr_byte;
    logic  wr_sput;
    logic  off_upd;
    logic  off_clr;
    logic  cnt_inc;
    logic  cnt_clr;
    logic  rd_issue;
    logic  emit;
    kind_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic can_emit;
    logic is_set;
    logic is_get;
    logic is_sput;
    logic is_sget;
    logic last;
    logic acc_viol;
    logic nb_zero;
    logic wr_last;
    logic rd_last;
    logic sput_wr_ok;
    logic sput_viol;
    logic sget_viol;
    logic sget_more;
    logic byte_zero;
  } stat_t;

endpackage

// File: hdl/typed_byte_memory_access.sv
// Top level of the typed byte memory access block.
// Instantiates tbma_ctrl and tbma_datapath; depends on tbma_pkg.
//
//  Channel  Handshake              Payload
//  cfg      cfg_we                 cfg_wdata (active_bytes)
//  in       in_valid / in_ready    in_op, in_position, in_write_value, in_string_last
//  out      out_valid / out_ready  out_kind, out_read_value, out_last_result
//
// After reset a clearing pass writes zero to all 1024 memory bytes, one per
// cycle, and no transaction is accepted until the clearing pass is complete.
// An item is accepted, then decoded, then its bytes are written or read one at
// a time on the single memory port; a string put writes its byte while it is
// decoded. A violation adds an emit state for its result.
// A stalled output holds the controller in its emit state.
module typed_byte_memory_access
  import tbma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ACTIVE_W-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_op,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [31:0]             in_write_value,
  input  logic                    in_string_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [31:0]             out_read_value,
  output logic                    out_last_result
);

  cmd_t  cmd;
  stat_t stat;

  tbma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbma_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .in_string_last  (in_string_last),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_read_value  (out_read_value),
    .out_last_result (out_last_result),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// File: hdl/tbma_ctrl.sv
// Controller state machine for the typed byte memory access block.
// Sequences clearing, byte writes, byte reads and result emission.
// Depends on tbma_pkg for the command and status structs.
module tbma_ctrl
  import tbma_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_EXEC  = 10'b00_0000_0100,
    S_WR    = 10'b00_0000_1000,
    S_GRD   = 10'b00_0001_0000,
    S_GFIN  = 10'b00_0010_0000,
    S_SRD   = 10'b00_0100_0000,
    S_SCHK  = 10'b00_1000_0000,
    S_SEND  = 10'b01_0000_0000,
    S_VIOL  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = KIND_VIOL;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_sput) begin
          cmd.wr_sput = stat.sput_wr_ok;
          cmd.off_upd = 1'b1;
          state_nxt   = (stat.last && stat.sput_viol) ? S_VIOL : S_IDLE;
        end else begin
          cmd.off_clr = 1'b1;
          if (stat.is_set) begin
            if (!stat.nb_zero) begin
              state_nxt = S_WR;
            end else begin
              state_nxt = stat.acc_viol ? S_VIOL : S_IDLE;
            end
          end else if (stat.is_get) begin
            state_nxt = stat.acc_viol ? S_VIOL : S_GRD;
          end else if (stat.is_sget) begin
            state_nxt = stat.sget_viol ? S_VIOL : S_SRD;
          end
        end
      end
      S_WR: begin
        cmd.wr_byte = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.wr_last) begin
          cmd.cnt_inc = 1'b0;
          cmd.cnt_clr = 1'b1;
          state_nxt   = stat.acc_viol ? S_VIOL : S_IDLE;
        end
      end
      S_GRD: begin
        cmd.rd_issue = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_GFIN;
        end
      end
      S_GFIN: begin
        cmd.emit_kind = KIND_VALUE;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRD: begin
        if (stat.sget_more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_SCHK;
        end else begin
          state_nxt = S_SEND;
        end
      end
      S_SCHK: begin
        cmd.emit_kind = KIND_CHAR;
        if (stat.byte_zero) begin
          state_nxt = S_SEND;
        end else if (stat.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SEND: begin
        cmd.emit_kind = KIND_END;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_VIOL: begin
        cmd.emit_kind = KIND_VIOL;
        if (stat.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/tbma_datapath.sv
// Datapath for the typed byte memory access block: item registers, size
// register, byte memory with registered read, assembly and result register.
// Depends on tbma_pkg; driven by tbma_ctrl through cmd_t and stat_t.
module tbma_datapath
  import tbma_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ACTIVE_W-1:0] cfg_wdata,
  input  logic [2:0]          in_op,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [31:0]         in_write_value,
  input  logic                in_string_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [31:0]         out_read_value,
  output logic                out_last_result,
  input  cmd_t                cmd,
  output stat_t               stat
);

  logic [7:0] mem [MEM_BYTES];

  logic [ACTIVE_W-1:0] active_r;
  op_t                 op_r;
  logic [POS_W-1:0]    pos_r;
  logic [31:0]         wv_r;
  logic                last_r;
  logic [OFF_W-1:0]    off_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [7:0]          mem_q_r;
  logic                rd_pend_r;
  logic [1:0]          lane_r;
  logic [31:0]         acc_r;
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [31:0]         out_value_r;
  logic                out_last_r;

  logic [CALC_W-1:0] size_c;
  logic [CALC_W-1:0] pos_u;
  logic [CALC_W-1:0] rem;
  logic [CALC_W-1:0] sput_addr;
  logic [CALC_W-1:0] byte_addr;
  logic [2:0]        width;
  logic [2:0]        nbytes;
  logic              neg;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [31:0]       get_value;

  always_comb begin
    if (32'(active_r) > MEM_BYTES) begin
      size_c = CALC_W'(MEM_BYTES);
    end else begin
      size_c = CALC_W'(active_r);
    end
  end

  assign neg       = pos_r[POS_W-1];
  assign pos_u     = CALC_W'(pos_r[POS_W-2:0]);
  assign rem       = size_c - pos_u;
  assign sput_addr = pos_u + CALC_W'(off_r);
  assign byte_addr = pos_u + CALC_W'(cnt_r);

  always_comb begin
    case (op_r) inside
      OP_SET_INT, OP_GET_INT:     width = 3'd4;
      OP_SET_SHORT, OP_GET_SHORT: width = 3'd2;
      default:                    width = 3'd1;
    endcase
  end

  always_comb begin
    if (neg || pos_u >= size_c) begin
      nbytes = 3'd0;
    end else if (rem > CALC_W'(width)) begin
      nbytes = width;
    end else begin
      nbytes = rem[2:0];
    end
  end

  assign stat.clr_done   = (clr_cnt_r == ADDR_W'(MEM_BYTES - 1));
  assign stat.can_emit   = !out_valid_r || out_ready;
  assign stat.is_set     = op_r inside {OP_SET_INT, OP_SET_SHORT, OP_SET_CHAR};
  assign stat.is_get     = op_r inside {OP_GET_INT, OP_GET_SHORT, OP_GET_CHAR};
  assign stat.is_sput    = (op_r == OP_STR_PUT);
  assign stat.is_sget    = (op_r == OP_STR_GET);
  assign stat.last       = last_r;
  assign stat.acc_viol   = neg || (pos_u + CALC_W'(width) > size_c);
  assign stat.nb_zero    = (nbytes == 3'd0);
  assign stat.wr_last    = (cnt_r + CNT_W'(1)) == CNT_W'(nbytes);
  assign stat.rd_last    = (cnt_r + CNT_W'(1)) == CNT_W'(width);
  assign stat.sput_wr_ok = !neg && (off_r != OFF_SAT) && (sput_addr < size_c);
  assign stat.sput_viol  = neg || (sput_addr + CALC_W'(1) >= size_c);
  assign stat.sget_viol  = neg || (pos_u >= size_c);
  assign stat.sget_more  = (cnt_r < CNT_W'(MAX_STRING)) && (byte_addr < size_c);
  assign stat.byte_zero  = (mem_q_r == 8'd0);

  always_comb begin
    mem_we = cmd.clr_wr || cmd.wr_byte || cmd.wr_sput;
    if (cmd.clr_wr) begin
      mem_wa = clr_cnt_r;
      mem_wd = 8'd0;
    end else if (cmd.wr_sput) begin
      mem_wa = sput_addr[ADDR_W-1:0];
      mem_wd = wv_r[7:0];
    end else begin
      mem_wa = byte_addr[ADDR_W-1:0];
      mem_wd = wv_r[{cnt_r[1:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_issue) begin
      mem_q_r <= mem[byte_addr[ADDR_W-1:0]];
    end
  end

  assign get_value = acc_r | (32'(mem_q_r) << {lane_r, 3'b000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RESET;
      off_r       <= '0;
      clr_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (cmd.off_clr) begin
        off_r <= '0;
      end else if (cmd.off_upd) begin
        if (last_r) begin
          off_r <= '0;
        end else if (off_r != OFF_SAT) begin
          off_r <= off_r + OFF_W'(1);
        end
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      rd_pend_r <= cmd.rd_issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      pos_r  <= in_position;
      wv_r   <= in_write_value;
      last_r <= in_string_last;
    end
    if (cmd.load || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.rd_issue) begin
      lane_r <= cnt_r[1:0];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= get_value;
    end
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_last_r <= (cmd.emit_kind != KIND_CHAR);
      case (cmd.emit_kind)
        KIND_VALUE: out_value_r <= get_value;
        KIND_CHAR:  out_value_r <= 32'(mem_q_r);
        default:    out_value_r <= '0;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_read_value  = out_value_r;
  assign out_last_result = out_last_r;

`ifndef SYNTHESIS
  a_emit_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("Result register overwritten before it was taken.");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && cmd.rd_issue))
    else $error("Memory read and write in the same cycle.");

  a_off_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (off_r == OFF_SAT) |=> (off_r == OFF_SAT || off_r == '0))
    else $error("String offset left saturation without being cleared.");

  a_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && stat.is_get) |-> (3'(lane_r) < width))
    else $error("Get read a byte beyond its access width.");
`endif

endmodule

// File: tb/typed_byte_memory_access_test.sv
// Self-checking testbench for typed_byte_memory_access: typed sets and gets, string streams
// and size settings, each result checked against a behavioral model of the byte memory.
// Depends on tbma_pkg and the RTL of typed_byte_memory_access.
`timescale 1ns / 100ps

module typed_byte_memory_access_test;
  import tbma_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } response_t;

  class memory_access_tracker;
    logic [7:0]       mem_image [MEM_BYTES];
    logic [OFF_W-1:0] stream_offset;
    int               active_bytes;
    response_t        pending_responses [$];
    int               errors;
    int               responses_seen;
    int               violations_seen;
    int               chars_seen;

    function new();
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      stream_offset   = '0;
      active_bytes    = ACTIVE_RESET;
      errors          = 0;
      responses_seen  = 0;
      violations_seen = 0;
      chars_seen      = 0;
    endfunction

    function void add_response(kind_t kind, logic [31:0] value, logic last);
      response_t r;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      pending_responses.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void note_access(op_t op, logic signed [POS_W-1:0] pos, logic [31:0] wv,
                              logic str_last);
      int          size;
      int          p;
      int          off;
      int          addr;
      int          width;
      int          fit;
      int          n;
      logic [31:0] v;
      size = (active_bytes > MEM_BYTES) ? MEM_BYTES : active_bytes;
      p = pos;
      if (op == OP_STR_PUT) begin
        off  = stream_offset;
        addr = p + off;
        if (stream_offset < OFF_SAT) begin
          if (p >= 0 && addr < size) mem_image[addr] = wv[7:0];
          stream_offset = stream_offset + 1'b1;
        end
        if (str_last) begin
          stream_offset = '0;
          if (p < 0 || p + off + 1 >= size) add_response(KIND_VIOL, '0, 1'b1);
        end
        return;
      end
      stream_offset = '0;
      if (p < 0) begin
        add_response(KIND_VIOL, '0, 1'b1);
        return;
      end
      if (op == OP_STR_GET) begin
        if (p >= size) begin
          add_response(KIND_VIOL, '0, 1'b1);
          return;
        end
        n    = 0;
        addr = p;
        while (n < MAX_STRING && addr < size && mem_image[addr] != 8'h00) begin
          add_response(KIND_CHAR, {24'h0, mem_image[addr]}, 1'b0);
          n++;
          addr++;
        end
        add_response(KIND_END, '0, 1'b1);
        return;
      end
      case (op)
        OP_SET_INT, OP_GET_INT:     width = 4;
        OP_SET_SHORT, OP_GET_SHORT: width = 2;
        default:                    width = 1;
      endcase
      if (op == OP_SET_INT || op == OP_SET_SHORT || op == OP_SET_CHAR) begin
        fit = size - p;
        if (fit > width) fit = width;
        for (int i = 0; i < fit; i++) mem_image[p + i] = wv[8*i +: 8];
        if (p + width > size) add_response(KIND_VIOL, '0, 1'b1);
        return;
      end
      if (p + width > size) begin
        add_response(KIND_VIOL, '0, 1'b1);
        return;
      end
      v = '0;
      for (int i = 0; i < width; i++) v[8*i +: 8] = mem_image[p + i];
      add_response(KIND_VALUE, v, 1'b1);
    endfunction

    function void check_response(logic [1:0] kind, logic [31:0] value, logic last);
      response_t want;
      responses_seen++;
      if (kind == KIND_VIOL) violations_seen++;
      if (kind == KIND_CHAR) chars_seen++;
      if (pending_responses.size() == 0) begin
        report($sformatf("unexpected result kind=%0d value=%h last=%b", kind, value, last));
        return;
      end
      want = pending_responses.pop_front();
      if (want.kind !== kind || want.value !== value || want.last !== last)
        report($sformatf("expected kind=%0d value=%h last=%b, got kind=%0d value=%h last=%b",
                         want.kind, want.value, want.last, kind, value, last));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [ACTIVE_W-1:0]     cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic [2:0]              in_op;
  logic signed [POS_W-1:0] in_position;
  logic [31:0]             in_write_value;
  logic                    in_string_last;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [1:0]              out_kind;
  logic [31:0]             out_read_value;
  logic                    out_last_result;

  memory_access_tracker tracker;

  op_t set_ops [3]       = '{OP_SET_INT, OP_SET_SHORT, OP_SET_CHAR};
  op_t get_ops [3]       = '{OP_GET_INT, OP_GET_SHORT, OP_GET_CHAR};
  int  access_widths [3] = '{4, 2, 1};

  int       items_sent     = 0;
  int       settings_used  = 0;
  int       burst_left     = 0;
  bit       steady_sender  = 1'b0;
  int       ready_mode     = 0;
  int       ready_hold     = 0;
  bit [6:0] ready_pattern  = 7'b1011001;

  typed_byte_memory_access dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .in_string_last  (in_string_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_read_value  (out_read_value),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_hold = $urandom_range(50, 300);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'($urandom_range(0, 1));
      default: out_ready = ready_pattern[0];
    endcase
    ready_pattern = {ready_pattern[0], ready_pattern[6:1]};
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_response(out_kind, out_read_value, out_last_result);
  end

  task automatic pace_sender();
    int gap;
    if (steady_sender) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_item(op_t op, int pos, logic [31:0] wv, logic str_last);
    in_valid       = 1'b1;
    in_op          = op;
    in_position    = pos[POS_W-1:0];
    in_write_value = wv;
    in_string_last = str_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_access(op, pos[POS_W-1:0], wv, str_last);
    items_sent++;
    @(negedge clk);
    pace_sender();
  endtask

  task automatic drain_and_configure(int value);
    in_valid = 1'b0;
    while (tracker.pending_responses.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value[ACTIVE_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.active_bytes = value;
    settings_used++;
  endtask

  function automatic int pick_position(int size, int span);
    int p;
    case ($urandom_range(0, 9))
      0:       p = -int'($urandom_range(1, 2048));
      1:       p = size - span + int'($urandom_range(0, 4)) - 2;
      2:       p = $urandom_range(size, 2047);
      default: p = $urandom_range(0, size - 1);
    endcase
    return p;
  endfunction

  function automatic logic [31:0] random_char(bit allow_zero);
    logic [31:0] ch;
    ch = $urandom;
    if (ch[7:0] == 8'h00 && !(allow_zero && $urandom_range(0, 9) == 0)) ch[0] = 1'b1;
    return ch;
  endfunction

  task automatic random_sequence(int size);
    int pick;
    int p;
    int len;
    int sel;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      sel = $urandom_range(0, 2);
      p = pick_position(size, access_widths[sel]);
      send_item(set_ops[sel], p, $urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) sel = $urandom_range(0, 2);
      send_item(get_ops[sel], p, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 13) begin
      len = $urandom_range(1, 8);
      p = pick_position(size, len + 1);
      for (int k = 0; k < len; k++)
        send_item(OP_STR_PUT, p, random_char(1'b1), k == len - 1);
      send_item(OP_STR_GET, p, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 15) begin
      len = $urandom_range(1, 3);
      p = pick_position(size, len);
      for (int k = 0; k < len; k++) send_item(OP_STR_PUT, p, random_char(1'b0), 1'b0);
      sel = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0)
        send_item(get_ops[sel], p, $urandom, 1'($urandom_range(0, 1)));
      else
        send_item(OP_STR_GET, p, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 17 && size >= 72) begin
      p = $urandom_range(0, size - 70);
      for (int k = 0; k < 17; k++)
        send_item(OP_SET_INT, p + 4 * k, $urandom | 32'h0101_0101, 1'($urandom_range(0, 1)));
      send_item(OP_STR_GET, p, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      p = $urandom_range(0, 4095);
      p -= 2048;
      send_item(op_t'($urandom_range(0, 7)), p, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          phase_sizes [7];
    int          random_base;
    int          phase;
    int          phase_start;
    int          size;
    logic [31:0] ch;
    phase_sizes    = '{1, 1024, 16, 2, 300, 1023, 64};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = ACTIVE_RESET;
    in_valid       = 1'b0;
    in_op          = OP_SET_INT;
    in_position    = '0;
    in_write_value = '0;
    in_string_last = 1'b0;
    tracker = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed accesses at the reset size of 1024 bytes.
    send_item(OP_GET_INT,   0,     32'h0000_0000, 1'b1);
    send_item(OP_SET_INT,   0,     32'hFFFF_FFFF, 1'b1);
    send_item(OP_GET_INT,   0,     32'h0000_0000, 1'b0);
    send_item(OP_SET_SHORT, 1,     32'h0000_0000, 1'b0);
    send_item(OP_GET_INT,   0,     32'hFFFF_FFFF, 1'b1);
    send_item(OP_SET_INT,   1020,  32'h4433_2211, 1'b0);
    send_item(OP_SET_INT,   1022,  32'hAABB_CCDD, 1'b0);
    send_item(OP_GET_INT,   1020,  32'h0000_0000, 1'b0);
    send_item(OP_SET_SHORT, 1023,  32'h1234_5566, 1'b1);
    send_item(OP_GET_CHAR,  1023,  32'h0000_0000, 1'b0);
    send_item(OP_SET_CHAR,  1024,  32'h0000_00FF, 1'b0);
    send_item(OP_GET_SHORT, 2047,  32'h0000_0000, 1'b0);
    send_item(OP_SET_INT,   -2048, 32'h8000_0001, 1'b0);
    send_item(OP_GET_CHAR,  -1,    32'h0000_0000, 1'b1);
    send_item(OP_STR_PUT,   100,   32'hFFFF_FF48, 1'b0);
    send_item(OP_STR_PUT,   100,   32'h0000_0069, 1'b1);
    send_item(OP_STR_GET,   100,   32'h0000_0000, 1'b0);
    send_item(OP_STR_PUT,   1022,  32'h0000_0061, 1'b0);
    send_item(OP_STR_PUT,   1022,  32'h0000_0062, 1'b0);
    send_item(OP_STR_PUT,   1022,  32'h0000_0063, 1'b1);
    send_item(OP_STR_GET,   1020,  32'h0000_0000, 1'b1);
    send_item(OP_STR_GET,   1024,  32'h0000_0000, 1'b0);
    send_item(OP_STR_GET,   -5,    32'h0000_0000, 1'b0);
    send_item(OP_STR_PUT,   200,   32'h0000_0078, 1'b0);
    send_item(OP_GET_CHAR,  200,   32'h0000_0000, 1'b0);
    send_item(OP_STR_PUT,   201,   32'h0000_0079, 1'b1);
    send_item(OP_STR_GET,   200,   32'h0000_0000, 1'b0);

    // A string longer than a string get returns in one transaction.
    drain_and_configure(1024);
    for (int k = 0; k < 70; k++) begin
      ch = $urandom;
      ch[7:0] = 8'($urandom_range(1, 255));
      send_item(OP_STR_PUT, 0, ch, k == 69);
    end
    send_item(OP_STR_GET, 0, $urandom, 1'b0);
    send_item(OP_STR_GET, 5, $urandom, 1'b1);

    random_base = items_sent;
    phase = 0;
    while (items_sent - random_base < 95) begin
      size = (phase < 7) ? phase_sizes[phase] : $urandom_range(1, 1024);
      drain_and_configure(size);
      steady_sender = (phase % 3 == 1);
      phase_start = items_sent;
      while (items_sent - phase_start < 15) random_sequence(size);
      steady_sender = 1'b0;
      phase++;
    end

    in_valid = 1'b0;
    while (tracker.pending_responses.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Sent %0d transactions over %0d size settings, one string past the get limit.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d violations, %0d string characters, %0d mismatches.",
             tracker.responses_seen, tracker.violations_seen, tracker.chars_seen,
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending_responses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: typed_byte_memory_access.f
hdl/tbma_pkg.sv
hdl/tbma_ctrl.sv
hdl/tbma_datapath.sv
hdl/typed_byte_memory_access.sv
tb/typed_byte_memory_access_test.sv
